// ----- src/kmn_pkg.sv -----
// ----------------------------------------------------------------------------
// kmn_pkg
// Shared types and constants of the key to MIDI note event translator.
// ----------------------------------------------------------------------------
package kmn_pkg;

  localparam int KeyW     = 4;
  localparam int ChanW    = 4;
  localparam int NoteW    = 7;
  localparam int VelW     = 7;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;

  localparam int MelodicKeysDefault = 12;
  localparam int QueueDepth         = 2;

  localparam logic [NoteW-1:0] NoteMax     = 7'd127;
  localparam logic [NoteW-1:0] OctaveStep  = 7'd12;
  localparam logic [NoteW-1:0] ChordStepA  = 7'd12;
  localparam logic [NoteW-1:0] ChordStepB  = 7'd19;
  localparam logic [VelW-1:0]  VelRelease  = 7'd64;
  localparam logic [VelW-1:0]  VelLoud     = 7'd126;
  localparam logic [VelW-1:0]  VelMedium   = 7'd80;
  localparam logic [NoteW-1:0] BaseReset   = 7'd36;

  localparam logic [ChanW-1:0] MelodicChanReset = 4'd4;
  localparam logic [ChanW-1:0] CymbalChanReset  = 4'd9;
  localparam logic [ChanW-1:0] RollChanReset    = 4'd10;
  localparam logic [NoteW-1:0] PercNoteReset    = 7'd40;
  localparam logic [VelW-1:0]  PercVelReset     = 7'd120;
  localparam logic [NoteW-1:0] LowestBaseReset  = 7'd36;
  localparam logic [NoteW-1:0] HighestBaseReset = 7'd84;

  typedef enum logic [KindW-1:0] {
    KindKey        = 2'd0,
    KindOctaveUp   = 2'd1,
    KindOctaveDown = 2'd2,
    KindVelSwitch  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMelodicChan = 3'd0,
    CfgCymbalChan  = 3'd1,
    CfgRollChan    = 3'd2,
    CfgPercNote    = 3'd3,
    CfgPercVel     = 3'd4,
    CfgLowestBase  = 3'd5,
    CfgHighestBase = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StepRoot   = 2'd0,
    StepOctave = 2'd1,
    StepFifth  = 2'd2
  } step_e;

  // One classified key event waiting to be expanded into messages
  typedef struct packed {
    logic             note_on;
    logic [ChanW-1:0] channel;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  root_vel;
    logic [VelW-1:0]  chord_vel;
    logic             chord;
  } job_t;

  function automatic logic [NoteW-1:0] sat_add(logic [NoteW-1:0] a, logic [NoteW-1:0] b);
    logic [NoteW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[NoteW] ? NoteMax : sum[NoteW-1:0];
  endfunction

endpackage

// ----- src/key_to_midi_note_events_core.sv -----
// ----------------------------------------------------------------------------
// key_to_midi_note_events_core
// Key press and release events in, MIDI note on and note off messages out.
// ----------------------------------------------------------------------------
// Input stream: one event per transfer. tuser carries the kind (key, octave
// up, octave down, velocity switch); tdata the key index, level, chord switch
// and any-key-held flag. Octave and velocity events only update state.
// Output stream: one MIDI message per transfer, tuser high for note on, tlast
// on the final message of an event. A valid key event yields one message, or
// three with the chord notes +12 and +19.
// Configuration: separate write channel, always ready; write it only while
// the block is idle.
// Flow: the first message of an event passes through the job queue and then
// the output register before it is offered. The message generator emits one
// message per cycle while jobs are queued and the receiver takes them; a
// two-entry job queue lets input transfers continue while messages are being
// sent. When the receiver stalls the output register holds its message and
// the queue fills, after which s_axis_tready drops. Reset restores the
// register defaults, octave base 36, medium velocity and a clear chord memory,
// and empties the queue.
// ----------------------------------------------------------------------------
module key_to_midi_note_events_core #(
  parameter int MELODIC_KEYS = kmn_pkg::MelodicKeysDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] key_index, [4] level, [5] chord_switch, [6] any_key_held, [7] zero
  input  logic [7:0]                   s_axis_tdata,
  // [1:0] kind
  input  logic [kmn_pkg::KindW-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] channel, [10:4] note, [17:11] velocity, [23:18] zero
  output logic [23:0]                  m_axis_tdata,
  // [0] note_on
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kmn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmn_pkg::CfgDataW-1:0] cfg_data_i
);
  import kmn_pkg::*;

  logic             push, full, pop, job_valid;
  job_t             push_job, head_job;
  logic [ChanW-1:0] channel;
  logic [NoteW-1:0] note;
  logic [VelW-1:0]  velocity;

  assign cfg_ready_o = 1'b1;

  kmn_front #(
    .MELODIC_KEYS(MELODIC_KEYS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .kind_i         (s_axis_tuser),
    .key_index_i    (s_axis_tdata[3:0]),
    .level_i        (s_axis_tdata[4]),
    .chord_switch_i (s_axis_tdata[5]),
    .any_key_held_i (s_axis_tdata[6]),
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  kmn_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  kmn_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .note_on_o   (m_axis_tuser),
    .channel_o   (channel),
    .note_o      (note),
    .velocity_o  (velocity),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, velocity, note, channel};

endmodule

// ----- src/kmn_front.sv -----
// ----------------------------------------------------------------------------
// kmn_front
// Accepts input events, holds configuration and player state, and turns each
// valid key event into one job for the message generator.
// ----------------------------------------------------------------------------
module kmn_front #(
  parameter int MELODIC_KEYS = kmn_pkg::MelodicKeysDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kmn_pkg::KindW-1:0]    kind_i,
  input  logic [kmn_pkg::KeyW-1:0]     key_index_i,
  input  logic                         level_i,
  input  logic                         chord_switch_i,
  input  logic                         any_key_held_i,
  input  logic                         cfg_valid_i,
  input  logic [kmn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmn_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         push_o,
  output kmn_pkg::job_t                job_o,
  input  logic                         full_i
);
  import kmn_pkg::*;

  localparam logic [KeyW:0] CymbalKey = (KeyW+1)'(MELODIC_KEYS);
  localparam logic [KeyW:0] RollKey   = (KeyW+1)'(MELODIC_KEYS + 1);

  logic [ChanW-1:0] melodic_chan_q, melodic_chan_d;
  logic [ChanW-1:0] cymbal_chan_q, cymbal_chan_d;
  logic [ChanW-1:0] roll_chan_q, roll_chan_d;
  logic [NoteW-1:0] perc_note_q, perc_note_d;
  logic [VelW-1:0]  perc_vel_q, perc_vel_d;
  logic [NoteW-1:0] lowest_base_q, lowest_base_d;
  logic [NoteW-1:0] highest_base_q, highest_base_d;

  logic [NoteW-1:0] base_q, base_d;
  logic             loud_q, loud_d;
  logic             chord_mem_q, chord_mem_d;

  logic             accept;
  logic [KeyW:0]    key_ext;
  logic             key_melodic, key_cymbal, key_roll, key_ok;
  logic [VelW-1:0]  key_vel;
  logic             octave_ok;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign key_ext    = {1'b0, key_index_i};
  assign key_melodic = key_ext < CymbalKey;
  assign key_cymbal  = key_ext == CymbalKey;
  assign key_roll    = key_ext == RollKey;
  assign key_ok      = key_melodic | key_cymbal | key_roll;
  assign octave_ok   = level_i & ~any_key_held_i;

  // Classify the key and build its job
  always_comb begin
    job_o = '0;
    priority if (key_melodic) begin
      key_vel       = loud_q ? VelLoud : VelMedium;
      job_o.channel = melodic_chan_q;
      job_o.note    = sat_add(base_q, NoteW'(key_index_i));
    end else if (key_cymbal) begin
      key_vel       = perc_vel_q;
      job_o.channel = cymbal_chan_q;
      job_o.note    = perc_note_q;
    end else begin
      key_vel       = perc_vel_q;
      job_o.channel = roll_chan_q;
      job_o.note    = perc_note_q;
    end
    job_o.note_on   = level_i;
    job_o.root_vel  = level_i ? key_vel : VelRelease;
    job_o.chord_vel = key_vel;
    job_o.chord     = level_i ? chord_switch_i : (chord_switch_i | chord_mem_q);
  end

  assign push_o = accept & (kind_e'(kind_i) == KindKey) & key_ok;

  // Player state
  always_comb begin
    base_d      = base_q;
    loud_d      = loud_q;
    chord_mem_d = chord_mem_q;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KindOctaveUp: begin
          if (octave_ok && base_q < highest_base_q) base_d = sat_add(base_q, OctaveStep);
        end
        KindOctaveDown: begin
          if (octave_ok && base_q > lowest_base_q) begin
            base_d = (base_q >= OctaveStep) ? base_q - OctaveStep : '0;
          end
        end
        KindVelSwitch: loud_d = level_i;
        KindKey: begin
          if (key_ok) chord_mem_d = level_i ? (chord_switch_i | chord_mem_q) : 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Configuration writes
  always_comb begin
    melodic_chan_d = melodic_chan_q;
    cymbal_chan_d  = cymbal_chan_q;
    roll_chan_d    = roll_chan_q;
    perc_note_d    = perc_note_q;
    perc_vel_d     = perc_vel_q;
    lowest_base_d  = lowest_base_q;
    highest_base_d = highest_base_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgMelodicChan: melodic_chan_d = cfg_data_i[ChanW-1:0];
        CfgCymbalChan:  cymbal_chan_d  = cfg_data_i[ChanW-1:0];
        CfgRollChan:    roll_chan_d    = cfg_data_i[ChanW-1:0];
        CfgPercNote:    perc_note_d    = cfg_data_i[NoteW-1:0];
        CfgPercVel:     perc_vel_d     = cfg_data_i[VelW-1:0];
        CfgLowestBase:  lowest_base_d  = cfg_data_i[NoteW-1:0];
        CfgHighestBase: highest_base_d = cfg_data_i[NoteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      melodic_chan_q <= MelodicChanReset;
      cymbal_chan_q  <= CymbalChanReset;
      roll_chan_q    <= RollChanReset;
      perc_note_q    <= PercNoteReset;
      perc_vel_q     <= PercVelReset;
      lowest_base_q  <= LowestBaseReset;
      highest_base_q <= HighestBaseReset;
      base_q         <= BaseReset;
      loud_q         <= 1'b0;
      chord_mem_q    <= 1'b0;
    end else begin
      melodic_chan_q <= melodic_chan_d;
      cymbal_chan_q  <= cymbal_chan_d;
      roll_chan_q    <= roll_chan_d;
      perc_note_q    <= perc_note_d;
      perc_vel_q     <= perc_vel_d;
      lowest_base_q  <= lowest_base_d;
      highest_base_q <= highest_base_d;
      base_q         <= base_d;
      loud_q         <= loud_d;
      chord_mem_q    <= chord_mem_d;
    end
  end

endmodule

// ----- src/kmn_queue.sv -----
// ----------------------------------------------------------------------------
// kmn_queue
// Short job queue between the event front end and the message generator.
// ----------------------------------------------------------------------------
module kmn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kmn_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output kmn_pkg::job_t head_o
);
  import kmn_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntFull;
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- src/kmn_back.sv -----
// ----------------------------------------------------------------------------
// kmn_back
// Expands the job at the queue head into one or three MIDI messages and
// holds each in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module kmn_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  kmn_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      note_on_o,
  output logic [kmn_pkg::ChanW-1:0] channel_o,
  output logic [kmn_pkg::NoteW-1:0] note_o,
  output logic [kmn_pkg::VelW-1:0]  velocity_o,
  output logic                      last_o
);
  import kmn_pkg::*;

  step_e            step_q, step_d;
  logic             load;
  logic             msg_last;
  logic [NoteW-1:0] msg_note;
  logic [VelW-1:0]  msg_vel;

  logic             valid_q;
  logic             note_on_q;
  logic [ChanW-1:0] channel_q;
  logic [NoteW-1:0] note_q;
  logic [VelW-1:0]  vel_q;
  logic             last_q;

  assign load  = job_valid_i & (~valid_q | out_ready_i);
  assign pop_o = load & msg_last;

  // Next step
  always_comb begin
    step_d = step_q;
    if (load) begin
      if (msg_last) step_d = StepRoot;
      else begin
        unique case (step_q)
          StepRoot:   step_d = StepOctave;
          StepOctave: step_d = StepFifth;
          default:    step_d = StepRoot;
        endcase
      end
    end
  end

  // Message of the current step
  always_comb begin
    unique case (step_q)
      StepRoot: begin
        msg_note = job_i.note;
        msg_vel  = job_i.root_vel;
        msg_last = ~job_i.chord;
      end
      StepOctave: begin
        msg_note = sat_add(job_i.note, ChordStepA);
        msg_vel  = job_i.chord_vel;
        msg_last = 1'b0;
      end
      default: begin
        msg_note = sat_add(job_i.note, ChordStepB);
        msg_vel  = job_i.chord_vel;
        msg_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepRoot;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      note_on_q <= job_i.note_on;
      channel_q <= job_i.channel;
      note_q    <= msg_note;
      vel_q     <= msg_vel;
      last_q    <= msg_last;
    end
  end

  assign out_valid_o = valid_q;
  assign note_on_o   = note_on_q;
  assign channel_o   = channel_q;
  assign note_o      = note_q;
  assign velocity_o  = vel_q;
  assign last_o      = last_q;

endmodule

// ----- src/kmn_checker.sv -----
// ----------------------------------------------------------------------------
// kmn_checker
// Port-level checks on the message stream, bound to the top level.
// ----------------------------------------------------------------------------
module kmn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic m_xfer;
  assign m_xfer = m_axis_tvalid & m_axis_tready;

  // Hold a stalled message
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // Chord messages follow the root without a gap
  a_chord_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a multi-message event");

  a_event_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> m_axis_tuser == $past(m_axis_tuser))
    else $error("note on flag changed inside an event");

  a_event_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]))
    else $error("channel changed inside an event");

endmodule

bind key_to_midi_note_events_core kmn_checker u_kmn_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .m_axis_tuser,
  .m_axis_tlast
);
